// ===== hdl/csw_pkg.sv =====
`timescale 1ns / 1ps

package csw_pkg;

    // Default width of one color channel.
    localparam int CHANNEL_BITS_DEF = 8;

    // Width of the result weight (0 to 100).
    localparam int WEIGHT_W = 7;

    // Number of weight levels and the width of a level bound.
    localparam int LEVELS     = 100;
    localparam int BOUND_W    = 12;

    // The level compares are split into groups that are counted in one stage
    // and summed in the next.
    localparam int GROUP_SIZE = 10;
    localparam int GROUPS     = LEVELS / GROUP_SIZE;
    localparam int GCOUNT_W   = $clog2(GROUP_SIZE + 1);

    // Level k+1 is reached when the squared distance is at most bound k.
    // The bound is floor((10 * ln(100 / (k + 1)))^2) and never increases with k.
    localparam logic [BOUND_W-1:0] LEVEL_BOUND [LEVELS] = '{
        12'd2120, 12'd1530, 12'd1229, 12'd1036, 12'd897,
        12'd791,  12'd707,  12'd637,  12'd579,  12'd530,
        12'd487,  12'd449,  12'd416,  12'd386,  12'd359,
        12'd335,  12'd313,  12'd294,  12'd275,  12'd259,
        12'd243,  12'd229,  12'd215,  12'd203,  12'd192,
        12'd181,  12'd171,  12'd162,  12'd153,  12'd144,
        12'd137,  12'd129,  12'd122,  12'd116,  12'd110,
        12'd104,  12'd98,   12'd93,   12'd88,   12'd83,
        12'd79,   12'd75,   12'd71,   12'd67,   12'd63,
        12'd60,   12'd57,   12'd53,   12'd50,   12'd48,
        12'd45,   12'd42,   12'd40,   12'd37,   12'd35,
        12'd33,   12'd31,   12'd29,   12'd27,   12'd26,
        12'd24,   12'd22,   12'd21,   12'd19,   12'd18,
        12'd17,   12'd16,   12'd14,   12'd13,   12'd12,
        12'd11,   12'd10,   12'd9,    12'd9,    12'd8,
        12'd7,    12'd6,    12'd6,    12'd5,    12'd4,
        12'd4,    12'd3,    12'd3,    12'd3,    12'd2,
        12'd2,    12'd1,    12'd1,    12'd1,    12'd1,
        12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
        12'd0,    12'd0,    12'd0,    12'd0,    12'd0
    };

endpackage

// ===== hdl/csw_level_count.sv =====
`timescale 1ns / 1ps

module csw_level_count #(
    parameter int SUM_W = 2 * csw_pkg::CHANNEL_BITS_DEF + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SUM_W-1:0]              dist_sq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csw_pkg::WEIGHT_W-1:0]  weight
);

    localparam int CMP_W = (SUM_W > csw_pkg::BOUND_W) ? SUM_W : csw_pkg::BOUND_W;

    logic                             cnt_valid_reg;
    logic [csw_pkg::GCOUNT_W-1:0]     gcount_reg [csw_pkg::GROUPS];
    logic [csw_pkg::GCOUNT_W-1:0]     gcount_next [csw_pkg::GROUPS];
    logic                             out_valid_reg;
    logic [csw_pkg::WEIGHT_W-1:0]     weight_reg;
    logic [csw_pkg::WEIGHT_W-1:0]     weight_next;
    logic                             adv_cnt;
    logic                             adv_out;
    logic [CMP_W-1:0]                 dist_ext;

    assign adv_out  = ~out_valid_reg | out_ready;
    assign adv_cnt  = ~cnt_valid_reg | adv_out;
    assign in_ready = adv_cnt;
    assign dist_ext = CMP_W'(dist_sq);

    // Each group counts how many of its bounds the distance does not exceed.
    always_comb
    begin
        for (int g = 0; g < csw_pkg::GROUPS; g++)
        begin
            gcount_next[g] = '0;
            for (int j = 0; j < csw_pkg::GROUP_SIZE; j++)
            begin
                if (dist_ext <= CMP_W'(csw_pkg::LEVEL_BOUND[g * csw_pkg::GROUP_SIZE + j]))
                begin
                    gcount_next[g] = gcount_next[g] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        weight_next = '0;
        for (int g = 0; g < csw_pkg::GROUPS; g++)
        begin
            weight_next = weight_next + csw_pkg::WEIGHT_W'(gcount_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_cnt)
            begin
                cnt_valid_reg <= in_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= cnt_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_cnt && in_valid)
        begin
            gcount_reg <= gcount_next;
        end
        if (adv_out && cnt_valid_reg)
        begin
            weight_reg <= weight_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;

endmodule

// ===== hdl/color_similarity_weight.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Word contents (lowest bit first)
// ---------+-----------+-------------------------------------------------------
// s_axis   | in        | red_a, green_a, blue_a, red_b, green_b, blue_b
// m_axis   | out       | weight (7 bits), one zero pad bit
//
// One pixel pair is taken every cycle while m_axis is not stalled, and each pair
// produces exactly one weight word. The five register stages are: channel
// differences, squares, the squared-distance sum, grouped level compares, and the
// final sum of group counts, which is also the output register.
// Reset clears only the valid bits of the stages. A stall on m_axis holds each
// stage that holds a word and lets bubbles ahead of it close up.

module color_similarity_weight #(
    parameter int CHANNEL_BITS = csw_pkg::CHANNEL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // red_a, green_a, blue_a, red_b, green_b, blue_b, then zero pad to bytes
    input  logic [((6*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // weight in the low 7 bits, then one zero pad bit
    output logic [7:0]                  m_axis_tdata
);

    localparam int CB    = CHANNEL_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;

    // Stage 1: absolute channel differences.
    logic                v1_reg;
    logic [CB-1:0]       diff_reg [3];
    logic [CB-1:0]       diff_next [3];
    // Stage 2: squared differences.
    logic                v2_reg;
    logic [SQ_W-1:0]     sq_reg [3];
    // Stage 3: squared color distance.
    logic                v3_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                adv1;
    logic                adv2;
    logic                adv3;
    logic                cnt_ready;
    logic [csw_pkg::WEIGHT_W-1:0] weight;

    assign adv3 = ~v3_reg | cnt_ready;
    assign adv2 = ~v2_reg | adv3;
    assign adv1 = ~v1_reg | adv2;
    assign s_axis_tready = adv1;

    // The first pixel's channels sit in the lower three fields.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [CB-1:0] a;
            logic [CB-1:0] b;
            a = s_axis_tdata[c*CB +: CB];
            b = s_axis_tdata[(c+3)*CB +: CB];
            diff_next[c] = (a >= b) ? (a - b) : (b - a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            diff_reg <= diff_next;
        end
        if (adv2 && v1_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= SQ_W'(diff_reg[c]) * SQ_W'(diff_reg[c]);
            end
        end
        if (adv3 && v2_reg)
        begin
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        end
    end

    csw_level_count #(
        .SUM_W (SUM_W)
    ) u_level_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (cnt_ready),
        .dist_sq   (sum_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .weight    (weight)
    );

    assign m_axis_tdata = {1'b0, weight};

endmodule
